/* design/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, codes and types for the sorted-array priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int COUNT_W    = $clog2(DEPTH + 1);

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((COUNT_W + DATA_WIDTH + 7) / 8) * 8;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_MISSING  = 2'd3
    } t_status;

    typedef logic signed [DATA_WIDTH-1:0] t_data;

    // Operation broadcast to every cell for the beat being accepted.
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctrl;

endpackage

/* design/spq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted array: holds an entry, compares it with the key and
// shifts towards or away from the head together with its neighbours.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  spq_pkg::t_data      i_key,
    input  logic                i_occ,        // slot lies below the fill level
    input  logic                i_ge_prev,    // ge flag of the cell nearer the head
    input  spq_pkg::t_data      i_entry_prev, // entry of the cell nearer the head
    input  spq_pkg::t_data      i_entry_next, // entry of the cell nearer the tail
    output logic                o_ge,
    output logic                o_eq,
    output spq_pkg::t_data      o_entry,
    output spq_pkg::t_data      n_entry
);

    spq_pkg::t_data r_entry;

    // An empty slot counts as smaller than any key, so the flags stay monotonic
    // along the row and mark the insert or delete position locally.
    assign o_ge    = !i_occ || (i_key >= r_entry);
    assign o_eq    = i_occ && (i_key == r_entry);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            if (i_ge_prev) begin
                n_entry = i_entry_prev;
            end else if (o_ge) begin
                n_entry = i_key;
            end
        end else if (i_ctrl.del) begin
            if (o_ge) begin
                n_entry = i_entry_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* design/sorted_array_priority_queue_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_core
// Bounded priority queue of signed values kept in descending order.
// ----------------------------------------------------------------------------
// All cells of the row compare their entry with the key in parallel and
// shift in the same cycle, and the result beat (status, count, head value)
// is registered in an output stage. A new beat is taken each cycle while the
// output stage is empty or being drained, so one operation per cycle is
// sustained. Slot contents need no clearing after reset; only the fill count
// and the output valid flag are reset.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [spq_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,  // [31:0] value
    input  logic                               i_s_axis_tuser,  // [0] cmd
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [spq_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,  // [4:0] count, [36:5] head_value
    output logic [1:0]                         o_m_axis_tuser   // [1:0] status
);

    localparam int D  = spq_pkg::DEPTH;
    localparam int DW = spq_pkg::DATA_WIDTH;
    localparam int CW = spq_pkg::COUNT_W;
    localparam int OUT_TDATA_W_PAD = spq_pkg::OUT_TDATA_W;

    logic [CW-1:0]       r_fill;
    logic [CW-1:0]       n_fill;
    logic                r_out_valid;
    spq_pkg::t_status    r_out_status;
    logic [CW-1:0]       r_out_count;
    spq_pkg::t_data      r_out_head;
    spq_pkg::t_status    n_status;

    logic                accept;
    logic                full;
    logic                found;
    spq_pkg::t_data      key;
    spq_pkg::t_cell_ctrl ctrl;

    logic [D-1:0]        ge_vec;
    logic [D-1:0]        eq_vec;
    logic [D-1:0]        occ_vec;
    spq_pkg::t_data      entry_q [D];
    spq_pkg::t_data      entry_d [D];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign key             = i_s_axis_tdata[DW-1:0];
    assign full            = (r_fill == CW'(D));
    assign found           = |eq_vec;

    always_comb begin
        ctrl.ins = accept && (i_s_axis_tuser == spq_pkg::CMD_INSERT) && !full;
        ctrl.del = accept && (i_s_axis_tuser == spq_pkg::CMD_DELETE) && found;
    end

    genvar g;
    generate
        for (g = 0; g < D; g++) begin : g_cell
            assign occ_vec[g] = (CW'(g) < r_fill);
            if (g == 0) begin : g_head
                spq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctrl       (ctrl),
                    .i_key        (key),
                    .i_occ        (occ_vec[g]),
                    .i_ge_prev    (1'b0),
                    .i_entry_prev (key),
                    .i_entry_next (entry_q[(g + 1) % D]),
                    .o_ge         (ge_vec[g]),
                    .o_eq         (eq_vec[g]),
                    .o_entry      (entry_q[g]),
                    .n_entry      (entry_d[g])
                );
            end else begin : g_body
                spq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctrl       (ctrl),
                    .i_key        (key),
                    .i_occ        (occ_vec[g]),
                    .i_ge_prev    (ge_vec[g-1]),
                    .i_entry_prev (entry_q[g-1]),
                    // The tail cell has no neighbour below; what it loads lies
                    // beyond the fill level after a delete.
                    .i_entry_next (entry_q[(g + 1) % D]),
                    .o_ge         (ge_vec[g]),
                    .o_eq         (eq_vec[g]),
                    .o_entry      (entry_q[g]),
                    .n_entry      (entry_d[g])
                );
            end
        end
    endgenerate

    always_comb begin
        n_fill   = r_fill;
        n_status = spq_pkg::ST_OK;
        if (i_s_axis_tuser == spq_pkg::CMD_INSERT) begin
            if (full) begin
                n_status = spq_pkg::ST_OVERFLOW;
            end else begin
                n_fill = r_fill + CW'(1);
            end
        end else if (r_fill == '0) begin
            n_status = spq_pkg::ST_EMPTY;
        end else if (!found) begin
            n_status = spq_pkg::ST_MISSING;
        end else begin
            n_fill = r_fill - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_status <= n_status;
            r_out_count  <= n_fill;
            r_out_head   <= (n_fill != '0) ? entry_d[0] : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = OUT_TDATA_W_PAD'({r_out_head, r_out_count});

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_array_priority_queue_core.
// ----------------------------------------------------------------------------
// A queue of insert and delete operations is built at time zero: a short
// directed opening walks the queue through empty, full and the value extremes.
// A random section follows in which the mix of inserts and deletes drifts
// between phases, so the queue keeps filling up and draining. Both stream
// sides pause at random. Every accepted operation is applied to a shadow copy
// of the sorted contents. Each result beat is checked against the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH       = spq_pkg::DEPTH;
    localparam int DATA_WIDTH  = spq_pkg::DATA_WIDTH;
    localparam int COUNT_W     = spq_pkg::COUNT_W;
    localparam int IN_TDATA_W  = spq_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = spq_pkg::OUT_TDATA_W;

    localparam int RANDOM_OPS  = 1425;
    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 28;
    localparam int QUIET_FROM  = 1500;
    localparam int QUIET_TO    = 3500;

    typedef struct {
        logic           cmd;
        spq_pkg::t_data value;
    } t_queue_op;

    typedef struct {
        spq_pkg::t_status     status;
        logic [COUNT_W-1:0]   count;
        spq_pkg::t_data       head;
    } t_queue_reply;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      s_valid;
    logic                      s_ready;
    logic [IN_TDATA_W-1:0]     s_data;
    logic                      s_user;
    logic                      m_valid;
    logic                      m_ready;
    logic [OUT_TDATA_W-1:0]    m_data;
    logic [1:0]                m_user;

    t_queue_op       pending_ops[$];
    t_queue_op       op_on_bus;
    spq_pkg::t_data  shadow_entries[$];
    t_queue_reply    due_replies[$];

    int cycle_no;
    int stall_cycles;
    int errors = 0;
    int beats_out = 0;
    int n_insert = 0;
    int n_delete = 0;
    int n_status[4] = '{default: 0};
    int deepest_fill = 0;

    sorted_array_priority_queue_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [31:0] value
        .i_s_axis_tuser  (s_user),   // [0] cmd
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // [4:0] count, [36:5] head_value
        .o_m_axis_tuser  (m_user)    // [1:0] status
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Random pauses, except for one long window where both sides run flat out.
    function automatic bit take_a_break();
        if (cycle_no >= QUIET_FROM && cycle_no < QUIET_TO) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        errors++;
        $display("mismatch on result beat %0d: %s got %0d, wanted %0d", beats_out, field,
                 got, want);
    endtask

    // Applies one operation to the shadow contents and records the reply it must give.
    task automatic predict_queue_op(input t_queue_op op);
        t_queue_reply reply;
        int pos;
        int hit;
        if (op.cmd == spq_pkg::CMD_INSERT) begin
            n_insert++;
            if (shadow_entries.size() >= DEPTH) begin
                reply.status = spq_pkg::ST_OVERFLOW;
            end else begin
                // New value goes ahead of older equal values.
                pos = shadow_entries.size();
                for (int j = 0; j < shadow_entries.size(); j++) begin
                    if (op.value >= shadow_entries[j]) begin
                        pos = j;
                        break;
                    end
                end
                shadow_entries.insert(pos, op.value);
                reply.status = spq_pkg::ST_OK;
            end
        end else begin
            n_delete++;
            if (shadow_entries.size() == 0) begin
                reply.status = spq_pkg::ST_EMPTY;
            end else begin
                hit = -1;
                for (int j = 0; j < shadow_entries.size(); j++) begin
                    if (shadow_entries[j] == op.value) begin
                        hit = j;
                        break;
                    end
                end
                if (hit >= 0) begin
                    shadow_entries.delete(hit);
                    reply.status = spq_pkg::ST_OK;
                end else begin
                    reply.status = spq_pkg::ST_MISSING;
                end
            end
        end
        reply.count = COUNT_W'(shadow_entries.size());
        reply.head  = (shadow_entries.size() > 0) ? shadow_entries[0]
                                                  : spq_pkg::t_data'(0);
        if (shadow_entries.size() > deepest_fill) begin
            deepest_fill = shadow_entries.size();
        end
        due_replies.push_back(reply);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cycle_no <= 0;
        end else begin
            cycle_no <= cycle_no + 1;
        end
    end

    // Request side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_queue_op(op_on_bus);
            end
            if (!s_valid || s_ready) begin
                if (pending_ops.size() > 0 && !take_a_break()) begin
                    op_on_bus = pending_ops.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= IN_TDATA_W'(op_on_bus.value);
                    s_user  <= op_on_bus.cmd;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Reply side.
    always @(posedge i_clk) begin
        t_queue_reply       want;
        spq_pkg::t_status   got_status;
        logic [COUNT_W-1:0] got_count;
        spq_pkg::t_data     got_head;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got_status = spq_pkg::t_status'(m_user);
                got_count  = m_data[COUNT_W-1:0];
                got_head   = m_data[COUNT_W +: DATA_WIDTH];
                if (due_replies.size() == 0) begin
                    errors++;
                    $display("result beat %0d arrived with no operation outstanding",
                             beats_out);
                end else begin
                    want = due_replies.pop_front();
                    n_status[want.status]++;
                    if (got_status !== want.status) begin
                        report_mismatch("status", got_status, want.status);
                    end
                    if (got_count !== want.count) begin
                        report_mismatch("count", got_count, want.count);
                    end
                    if (got_head !== want.head) begin
                        report_mismatch("head_value", got_head, want.head);
                    end
                end
                beats_out++;
            end
            m_ready <= !take_a_break();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("no beat moved for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_op(input logic cmd, input spq_pkg::t_data value);
        t_queue_op op;
        op.cmd   = cmd;
        op.value = value;
        pending_ops.push_back(op);
    endtask

    initial begin
        spq_pkg::t_data recent[$];
        spq_pkg::t_data v;
        logic  cmd;
        int    insert_pct;
        int    pick;
        int    total;

        i_rst_n = 1'b0;

        // Directed opening: empty queue, extremes, duplicates, missing values,
        // emptying by delete, then filling to the brim and one insert too many.
        queue_op(spq_pkg::CMD_DELETE, spq_pkg::t_data'(0));
        queue_op(spq_pkg::CMD_INSERT, spq_pkg::t_data'(42));
        queue_op(spq_pkg::CMD_DELETE, spq_pkg::t_data'(42));
        queue_op(spq_pkg::CMD_INSERT, spq_pkg::t_data'(32'h7fff_ffff));
        queue_op(spq_pkg::CMD_INSERT, spq_pkg::t_data'(32'h8000_0000));
        queue_op(spq_pkg::CMD_INSERT, spq_pkg::t_data'(0));
        queue_op(spq_pkg::CMD_INSERT, spq_pkg::t_data'(-1));
        queue_op(spq_pkg::CMD_INSERT, spq_pkg::t_data'(0));
        queue_op(spq_pkg::CMD_DELETE, spq_pkg::t_data'(5));
        queue_op(spq_pkg::CMD_DELETE, spq_pkg::t_data'(32'h8000_0000));
        queue_op(spq_pkg::CMD_DELETE, spq_pkg::t_data'(32'h7fff_ffff));
        queue_op(spq_pkg::CMD_INSERT, spq_pkg::t_data'(32'h5555_5555));
        queue_op(spq_pkg::CMD_INSERT, spq_pkg::t_data'(32'haaaa_aaaa));
        for (int k = 0; k < 11; k++) begin
            queue_op(spq_pkg::CMD_INSERT, spq_pkg::t_data'($urandom));
        end
        queue_op(spq_pkg::CMD_INSERT, spq_pkg::t_data'(7));

        // Random section: the insert share swings between phases so that the
        // queue alternates between running dry and running full. Deletes mostly
        // target values inserted not long ago so that many of them hit.
        insert_pct = 50;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 15;
                    1:       insert_pct = 50;
                    default: insert_pct = 85;
                endcase
            end
            cmd  = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::CMD_INSERT
                                                         : spq_pkg::CMD_DELETE;
            pick = $urandom_range(0, 99);
            if (cmd == spq_pkg::CMD_DELETE && recent.size() > 0 && pick < 60) begin
                v = recent[$urandom_range(0, recent.size() - 1)];
            end else if (pick < 75) begin
                v = spq_pkg::t_data'(int'($urandom_range(0, 16)) - 8);
            end else if (pick < 80) begin
                v = $urandom_range(0, 1) ? spq_pkg::t_data'(32'h7fff_ffff)
                                         : spq_pkg::t_data'(32'h8000_0000);
            end else begin
                v = spq_pkg::t_data'($urandom);
            end
            if (cmd == spq_pkg::CMD_INSERT) begin
                recent.push_back(v);
                if (recent.size() > 24) begin
                    void'(recent.pop_front());
                end
            end
            queue_op(cmd, v);
        end
        total = pending_ops.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_ops.size() == 0 && !s_valid && due_replies.size() == 0);
        repeat (6) @(posedge i_clk);

        $display("Ran %0d operations (%0d inserts, %0d deletes); depth peaked at %0d of %0d.",
                 total, n_insert, n_delete, deepest_fill, DEPTH);
        $display("Replies seen: %0d ok, %0d overflow, %0d empty, %0d not found.",
                 n_status[spq_pkg::ST_OK], n_status[spq_pkg::ST_OVERFLOW],
                 n_status[spq_pkg::ST_EMPTY], n_status[spq_pkg::ST_MISSING]);
        if (errors == 0 && due_replies.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
